// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the mode tracker datapath.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define MMT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequence checked in the cycle after its trigger.
`define MMT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/mmt_pkg.sv -----
// ----------------------------------------------------------------------------
// mmt_pkg
// Field widths, command and status codes, and controller/datapath bundles.
// ----------------------------------------------------------------------------
package mmt_pkg;

  localparam int unsigned DEF_VALUE_RANGE = 1024;
  localparam int unsigned DEF_COUNT_LIMIT = 1024;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned VALUE_W = 10;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned TOP_W   = 11;
  localparam int unsigned MODE_W  = 10;
  localparam int unsigned IN_W    = 16;
  localparam int unsigned OUT_W   = 24;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_ABSENT    = 2'd1;
  localparam logic [STAT_W-1:0] ST_SATURATED = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic              clr_step;
    logic              latch_in;
    logic              rd_vc;
    logic              rd_pop;
    logic              upd1;
    logic              upd2;
    logic              scan_start;
    logic              scan_step;
    logic              set_res;
    logic [STAT_W-1:0] res_status;
    logic              res_from_scan;
    logic              emit;
  } mmt_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_add;
    logic is_remove;
    logic in_range;
    logic top_zero;
    logic saturated;
    logic absent;
    logic hit;
    logic out_free;
  } mmt_stat_t;

endpackage

// ----- hdl/mmt_ctrl.sv -----
// ----------------------------------------------------------------------------
// mmt_ctrl
// Sequencer: clear pass, command decode, read-modify-write steps, mode scan.
// ----------------------------------------------------------------------------
module mmt_ctrl
  import mmt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  mmt_stat_t stat,
  output mmt_cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_CHK    = 4'd3;
  localparam logic [3:0] S_UPD1   = 4'd4;
  localparam logic [3:0] S_UPD2   = 4'd5;
  localparam logic [3:0] S_SCAN   = 4'd6;
  localparam logic [3:0] S_EMIT   = 4'd7;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!stat.is_add && !stat.is_remove) begin
          if (stat.top_zero) begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_EMPTY;
            state_next     = S_EMIT;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
        end else if (!stat.in_range) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = stat.is_add ? ST_SATURATED : ST_ABSENT;
          state_next     = S_EMIT;
        end else begin
          cmd.rd_vc  = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.is_add && stat.saturated) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_SATURATED;
          state_next     = S_EMIT;
        end else if (stat.is_remove && stat.absent) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_ABSENT;
          state_next     = S_EMIT;
        end else begin
          cmd.rd_pop = 1'b1;
          state_next = S_UPD1;
        end
      end
      S_UPD1: begin
        cmd.upd1   = 1'b1;
        state_next = S_UPD2;
      end
      S_UPD2: begin
        cmd.upd2       = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_OK;
        state_next     = S_EMIT;
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.set_res       = 1'b1;
          cmd.res_status    = ST_OK;
          cmd.res_from_scan = 1'b1;
          state_next        = S_EMIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/mmt_dp.sv -----
// ----------------------------------------------------------------------------
// mmt_dp
// Count store, count histogram, top count, scan pipeline and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmt_dp
  import mmt_pkg::*;
#(
  parameter int unsigned VALUE_RANGE = DEF_VALUE_RANGE,
  parameter int unsigned COUNT_LIMIT = DEF_COUNT_LIMIT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  input  mmt_cmd_t         cmd,
  output mmt_stat_t        stat
);

  localparam int unsigned AW        = $clog2(VALUE_RANGE);
  localparam int unsigned CW        = $clog2(COUNT_LIMIT + 1);
  localparam int unsigned PCW       = $clog2(VALUE_RANGE + 1);
  localparam int unsigned POP_DEPTH = COUNT_LIMIT + 1;
  localparam int unsigned CLR_DEPTH = (VALUE_RANGE > POP_DEPTH) ? VALUE_RANGE : POP_DEPTH;
  localparam int unsigned CLRW      = $clog2(CLR_DEPTH);

  logic [CW-1:0]  vc_mem [VALUE_RANGE];
  logic [PCW-1:0] pop_mem [POP_DEPTH];

  logic [CMD_W-1:0]   cmd_r;
  logic [VALUE_W-1:0] val_r;
  logic [16:0]        val_ext;
  logic [AW-1:0]      val_addr;

  logic [CLRW-1:0] clr_addr;
  logic            clr_in_vc;
  logic            clr_in_pop;

  logic [CW-1:0]  vc_rd;
  logic [PCW-1:0] pop_rd;
  logic [CW-1:0]  top;
  logic [CW-1:0]  c_nb;

  logic           vc_we, vc_re;
  logic [AW-1:0]  vc_waddr, vc_raddr;
  logic [CW-1:0]  vc_wdata;
  logic           pop_we, pop_re;
  logic [CW-1:0]  pop_waddr, pop_raddr;
  logic [PCW-1:0] pop_wdata;

  logic [AW-1:0] scan_addr;
  logic [AW-1:0] scan_addr_d;
  logic          scan_pipe;

  logic [STAT_W-1:0] res_status;
  logic [AW-1:0]     res_mode;
  logic [16:0]       top_ext;
  logic [16:0]       mode_ext;

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r <= s_tdata[CMD_W-1:0];
      val_r <= s_tdata[CMD_W +: VALUE_W];
    end
  end

  assign val_ext  = {7'd0, val_r};
  assign val_addr = val_ext[AW-1:0];

  // Clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + CLRW'(1);
    end
  end

  assign clr_in_vc  = (int'(clr_addr) < int'(VALUE_RANGE));
  assign clr_in_pop = (int'(clr_addr) < int'(POP_DEPTH));

  // Neighbor count: one above on add, one below on remove
  assign c_nb = stat.is_add ? vc_rd + CW'(1) : vc_rd - CW'(1);

  always_comb begin
    vc_we    = (cmd.clr_step && clr_in_vc) || cmd.upd1;
    vc_waddr = cmd.clr_step ? clr_addr[AW-1:0] : val_addr;
    vc_wdata = cmd.clr_step ? '0 : c_nb;
    vc_re    = cmd.rd_vc || cmd.scan_step;
    vc_raddr = cmd.scan_step ? scan_addr : val_addr;

    pop_we = (cmd.clr_step && clr_in_pop)
          || (cmd.upd1 && (!stat.is_add || vc_rd != '0))
          || (cmd.upd2 && (stat.is_add || vc_rd != CW'(1)));
    if (cmd.clr_step) begin
      pop_waddr = clr_addr[CW-1:0];
      pop_wdata = '0;
    end else if (cmd.upd1) begin
      pop_waddr = vc_rd;
      pop_wdata = pop_rd - PCW'(1);
    end else begin
      pop_waddr = c_nb;
      pop_wdata = pop_rd + PCW'(1);
    end
    pop_re    = cmd.rd_pop || cmd.upd1;
    pop_raddr = cmd.rd_pop ? vc_rd : c_nb;
  end

  always_ff @(posedge clk) begin
    if (vc_we) vc_mem[vc_waddr] <= vc_wdata;
    if (vc_re) vc_rd <= vc_mem[vc_raddr];
  end

  always_ff @(posedge clk) begin
    if (pop_we) pop_mem[pop_waddr] <= pop_wdata;
    if (pop_re) pop_rd <= pop_mem[pop_raddr];
  end

  // Top count: rise on an add at the top, fall when the last top value leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      top <= '0;
    end else if (cmd.upd1 && vc_rd == top) begin
      if (stat.is_add) begin
        top <= c_nb;
      end else if (pop_rd == PCW'(1)) begin
        top <= c_nb;
      end
    end
  end

  // Scan pipeline: address goes out, data returns in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pipe <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_pipe <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_pipe <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_addr <= '0;
    end else if (cmd.scan_step) begin
      scan_addr   <= scan_addr + AW'(1);
      scan_addr_d <= scan_addr;
    end
  end

  // Result staging and output register
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      res_mode   <= cmd.res_from_scan ? scan_addr_d : '0;
    end
  end

  assign top_ext  = 17'(top);
  assign mode_ext = 17'(res_mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= {1'b0, mode_ext[MODE_W-1:0], top_ext[TOP_W-1:0], res_status};
    end
  end

  always_comb begin
    stat.clr_done  = (int'(clr_addr) == int'(CLR_DEPTH - 1));
    stat.is_add    = (cmd_r == CMD_ADD);
    stat.is_remove = (cmd_r == CMD_REMOVE);
    stat.in_range  = (val_ext < 17'(VALUE_RANGE));
    stat.top_zero  = (top == '0);
    stat.saturated = (vc_rd == CW'(COUNT_LIMIT));
    stat.absent    = (vc_rd == '0);
    stat.hit       = scan_pipe && (vc_rd == top);
    stat.out_free  = !m_tvalid || m_tready;
  end

  `MMT_ASSERT(a_top_le_limit, clk, rst, top <= CW'(COUNT_LIMIT), "top count above limit")
  `MMT_ASSERT(a_emit_free, clk, rst, !cmd.emit || !m_tvalid || m_tready, "result overwritten")
  `MMT_ASSERT_NEXT(a_emit_valid, clk, rst, cmd.emit, m_tvalid, "emitted result not shown")
  `MMT_ASSERT_NEXT(a_top_rise, clk, rst, cmd.upd1 && stat.is_add && vc_rd == top, top == $past(vc_rd) + CW'(1), "top count did not rise")

endmodule

// ----- hdl/multiset_mode_tracker_core.sv -----
// ----------------------------------------------------------------------------
// multiset_mode_tracker_core
// Multiset of value codes with add, remove and mode query commands.
// ----------------------------------------------------------------------------
// Each input transaction carries one command (add, remove, query; code 3 acts
// as a query) and returns exactly one result transaction with a status, the
// current top count and, on a query, the smallest value that holds it. After
// reset the block sweeps both the count store and the count histogram to
// zero, one entry per cycle, over max(VALUE_RANGE, COUNT_LIMIT + 1) entries
// (1025 with the defaults); s_tready stays low until the sweep ends. One item
// is worked on at a time. An add or remove reads the count, reads the
// histogram entry and makes two histogram writes; one refused at the count
// check ends after the count read; a query of an empty set or an add or
// remove on an out-of-range value is answered at decode; and a query of a
// non-empty set scans the count store's single read port one entry per cycle
// from value 0 up until it finds the top count. A finished result waits in an
// output register, and the next transaction is accepted while it waits; a
// second finished result holds the block until the first one leaves.
// ----------------------------------------------------------------------------
module multiset_mode_tracker_core
  import mmt_pkg::*;
#(
  parameter int unsigned VALUE_RANGE = DEF_VALUE_RANGE,
  parameter int unsigned COUNT_LIMIT = DEF_COUNT_LIMIT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // command[1:0], value[11:2], zero pad
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // status[1:0], top_count[12:2],
                                      // mode_value[22:13], zero pad
);

  mmt_cmd_t  cmd;
  mmt_stat_t stat;

  // Sequencer: owns the input handshake and steps the datapath
  mmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage, top count tracking, scan and result register
  mmt_dp #(
    .VALUE_RANGE (VALUE_RANGE),
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// ----- test/mmt_mode_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mmt_mode_checker
// Watches both stream channels of the mode tracker, predicts each result from
// its own multiset copy and compares the results field by field.
// ----------------------------------------------------------------------------
module mmt_mode_checker
  import mmt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // command[1:0], value[11:2], zero pad
  input  logic             m_tvalid,
  input  logic             m_tready,
  input  logic [OUT_W-1:0] m_tdata,   // status[1:0], top_count[12:2],
                                      // mode_value[22:13], zero pad
  output int               failures,
  output int               pending,
  output int               commands,
  output int               queries,
  output int               empties,
  output int               absents,
  output int               saturations,
  output int               highest_top
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TOP_W-1:0]  top_count;
    logic [MODE_W-1:0] mode_value;
  } mode_result_t;

  // Shadow multiset: copies per value, values per copy count, current peak.
  logic [TOP_W-1:0] tally  [0:DEF_VALUE_RANGE-1];
  logic [TOP_W-1:0] census [0:DEF_COUNT_LIMIT];
  logic [TOP_W-1:0] peak;

  mode_result_t awaited_results[$];

  int n_err, n_cmd, n_query, n_empty, n_absent, n_sat, n_high;

  function automatic mode_result_t apply_command(input logic [CMD_W-1:0]   cmd,
                                                 input logic [VALUE_W-1:0] val);
    mode_result_t     r;
    logic [TOP_W-1:0] c;
    bit               found;
    r = '0;
    r.status = ST_OK;
    c = tally[val];
    case (cmd)
      CMD_ADD: begin
        if (c >= TOP_W'(DEF_COUNT_LIMIT)) begin
          r.status = ST_SATURATED;
        end else begin
          if (c == peak) peak = c + 1'b1;
          if (c != 0) census[c] = census[c] - 1'b1;
          tally[val] = c + 1'b1;
          census[c + 1'b1] = census[c + 1'b1] + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (c == 0) begin
          r.status = ST_ABSENT;
        end else begin
          // the peak only drops when its last holder loses a copy
          if (c == peak && census[c] == 1) peak = c - 1'b1;
          census[c] = census[c] - 1'b1;
          tally[val] = c - 1'b1;
          if (c > 1) census[c - 1'b1] = census[c - 1'b1] + 1'b1;
        end
      end
      default: begin
        // query, and the spare code that behaves as one
        if (peak == 0) begin
          r.status = ST_EMPTY;
        end else begin
          found = 1'b0;
          for (int i = 0; i < DEF_VALUE_RANGE; i++) begin
            if (!found && tally[i] == peak) begin
              r.mode_value = MODE_W'(i);
              found = 1'b1;
            end
          end
        end
      end
    endcase
    r.top_count = peak;
    return r;
  endfunction

  always @(posedge clk) begin
    mode_result_t got, want;
    if (rst) begin
      for (int i = 0; i < DEF_VALUE_RANGE; i++) tally[i] = '0;
      for (int i = 0; i <= DEF_COUNT_LIMIT; i++) census[i] = '0;
      peak = '0;
      awaited_results.delete();
      n_err = 0; n_cmd = 0; n_query = 0; n_empty = 0;
      n_absent = 0; n_sat = 0; n_high = 0;
    end else begin
      // Compare the result first: it always belongs to an earlier command.
      if (m_tvalid && m_tready) begin
        got.status     = m_tdata[1:0];
        got.top_count  = m_tdata[12:2];
        got.mode_value = m_tdata[22:13];
        if (awaited_results.size() == 0) begin
          $error("result with nothing awaited: status %0d top_count %0d mode_value %0d",
                 got.status, got.top_count, got.mode_value);
          n_err++;
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            n_err++;
          end
          if (got.top_count !== want.top_count) begin
            $error("top_count: expected %0d, actual %0d", want.top_count, got.top_count);
            n_err++;
          end
          if (got.mode_value !== want.mode_value) begin
            $error("mode_value: expected %0d, actual %0d", want.mode_value, got.mode_value);
            n_err++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = apply_command(s_tdata[1:0], s_tdata[11:2]);
        awaited_results.insert(awaited_results.size(), want);
        n_cmd++;
        if (s_tdata[1:0] != CMD_ADD && s_tdata[1:0] != CMD_REMOVE) n_query++;
        case (want.status)
          ST_EMPTY:     n_empty++;
          ST_ABSENT:    n_absent++;
          ST_SATURATED: n_sat++;
          default: ;
        endcase
        if (int'(want.top_count) > n_high) n_high = int'(want.top_count);
      end
    end
    failures    <= n_err;
    pending     <= awaited_results.size();
    commands    <= n_cmd;
    queries     <= n_query;
    empties     <= n_empty;
    absents     <= n_absent;
    saturations <= n_sat;
    highest_top <= n_high;
  end

endmodule

// ----- test/multiset_mode_tracker_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multiset_mode_tracker_core_test
// Drives add, remove and query commands into the mode tracker: a directed
// sequence, a climb of one value to a deep count and back, then random
// traffic over a small value pool, with random stalls on both sides and one
// long output hold-off. A checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module multiset_mode_tracker_core_test;
  import mmt_pkg::*;

  // Spare command code; the block treats it as a query.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam int RANDOM_ITEMS = 354;
  localparam int QUIET_TAIL   = 80;    // last random items run without idling
  localparam int HOLD_AT      = 60;    // random item that triggers the hold-off
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 6000;  // covers the clear sweep, a full scan
                                       // and the hold-off with margin
  localparam int DRAIN_CYCLES = 64;
  localparam int CLIMB_COUNT  = 100;
  localparam logic [VALUE_W-1:0] CLIMB_VALUE = 10'd597;

  logic             clk;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;   // command[1:0], value[11:2], zero pad
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;         // status[1:0], top_count[12:2],
                                     // mode_value[22:13], zero pad

  int failures, pending, commands, queries, empties, absents, saturations;
  int highest_top;

  bit quiet     = 1'b0;  // no idling on either side
  bit hold_go   = 1'b0;  // ask the receiver for its long hold-off
  bit hold_done = 1'b0;
  bit holding   = 1'b0;

  multiset_mode_tracker_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  mmt_mode_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .failures    (failures),
    .pending     (pending),
    .commands    (commands),
    .queries     (queries),
    .empties     (empties),
    .absents     (absents),
    .saturations (saturations),
    .highest_top (highest_top)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offer one command, starting at a falling edge, and return at the falling
  // edge after its transaction. Valid stays high into the next call unless a
  // gap is drawn, so back-to-back commands are offered without a gap.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val);
    if (!quiet && !holding && $urandom_range(0, 4) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {{(IN_W - CMD_W - VALUE_W){1'b0}}, val, cmd};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    logic [VALUE_W-1:0] pool [0:7];
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] val;
    int                 pick;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty queries, absent removes, extreme values, ties at the
    // top resolved to the smaller value, and the top falling only when its
    // sole holder is removed.
    send_command(CMD_QUERY,  10'd0);
    send_command(CMD_SPARE,  10'd0);
    send_command(CMD_REMOVE, 10'd0);
    send_command(CMD_REMOVE, 10'd1023);
    send_command(CMD_ADD,    10'd0);
    send_command(CMD_ADD,    10'd1023);
    send_command(CMD_ADD,    10'd1023);
    send_command(CMD_QUERY,  10'd0);
    send_command(CMD_ADD,    10'd0);
    send_command(CMD_QUERY,  10'd1023);
    send_command(CMD_REMOVE, 10'd0);
    send_command(CMD_SPARE,  10'd0);
    send_command(CMD_REMOVE, 10'd1023);
    send_command(CMD_QUERY,  10'd0);
    send_command(CMD_ADD,    10'd682);
    send_command(CMD_ADD,    10'd341);
    send_command(CMD_REMOVE, 10'd0);
    send_command(CMD_REMOVE, 10'd1023);
    send_command(CMD_QUERY,  10'd0);
    send_command(CMD_REMOVE, 10'd341);
    send_command(CMD_REMOVE, 10'd682);
    send_command(CMD_QUERY,  10'd0);
    send_command(CMD_REMOVE, 10'd682);

    // Climb one value to a deep count, then drain it back past empty.
    repeat (CLIMB_COUNT) send_command(CMD_ADD, CLIMB_VALUE);
    send_command(CMD_QUERY, 10'd0);
    repeat (CLIMB_COUNT) send_command(CMD_REMOVE, CLIMB_VALUE);
    send_command(CMD_REMOVE, CLIMB_VALUE);
    send_command(CMD_QUERY, 10'd0);

    // Random: mostly a small pool so counts build up and the mode moves.
    for (int i = 0; i < 8; i++) pool[i] = VALUE_W'($urandom_range(0, 1023));
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT) hold_go = 1'b1;
      if (n == RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
      if ($urandom_range(0, 19) == 0) pool[$urandom_range(0, 7)] = VALUE_W'($urandom);
      if ($urandom_range(0, 9) < 8) val = pool[$urandom_range(0, 7)];
      else                          val = VALUE_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45)      cmd = CMD_ADD;
      else if (pick < 75) cmd = CMD_REMOVE;
      else if (pick < 95) cmd = CMD_QUERY;
      else                cmd = CMD_SPARE;
      send_command(cmd, val);
    end
    s_tvalid = 1'b0;

    // Drain: wait for every awaited result, then watch for strays.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d commands, %0d queries (%0d on an empty set), peak top count %0d",
             commands, queries, empties, highest_top);
    $display("run: %0d removes of absent values, %0d adds refused at the count limit",
             absents, saturations);
    if (failures == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver: random ready bursts, one long hold-off so the block backs up
  // into its input, and steady ready in the quiet tail.
  initial begin : receiver
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_go && !hold_done) begin
        holding  = 1'b1;
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holding   = 1'b0;
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        m_tready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else                                                  idle++;
      if (idle >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results awaited",
                 STALL_LIMIT, pending);
        $display("tb: failure");
        $finish;
      end
    end
  end

endmodule
